[rtl/frir_pkg.sv]
// frir_pkg: shared types and constants of the frame interval ring recorder
// no dependencies
package frir_pkg;

  localparam int unsigned SUM_W    = 44;   // interval sum, up to 4096 x 32-bit
  localparam int unsigned IV_W     = 32;
  localparam int unsigned RATE_W   = 38;
  localparam int unsigned CNT_W    = 13;   // stored_count and rate_window width
  localparam int unsigned GOT_W    = 7;
  localparam logic [GOT_W-1:0] MAX_RES = 7'd64;
  localparam logic [SUM_W-1:0] RATE_NUM = 44'd256000000000;
  localparam logic [CNT_W-1:0] RATE_WIN_RST = 13'd60;

  typedef enum logic [2:0] {
    ACT_RECORD = 3'd0,
    ACT_LATEST = 3'd1,
    ACT_SINCE  = 3'd2,
    ACT_AVG    = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_RATE   = 3'd5
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LAT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_END,
    S_AVG,
    S_DIV1,
    S_DIV2,
    S_AVG_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] frame;
    logic [63:0] stamp;
    logic [31:0] interval;
    logic [31:0] duration;
  } entry_t;

  typedef struct packed {
    logic              status;
    logic [63:0]       frame_no_out;
    logic [63:0]       timestamp_out;
    logic [31:0]       frame_interval_ns;
    logic [31:0]       present_duration_ns;
    logic [CNT_W-1:0]  stored_count;
    logic [31:0]       average_interval_ns;
    logic [RATE_W-1:0] rate_q8;
    logic              last;
  } result_t;

endpackage

[rtl/frir_if.sv]
// frir_if: valid/ready channel interfaces for request and result items
// depends on frir_pkg
interface frir_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] frame_no;
  logic [63:0] start_time;
  logic [63:0] end_time;
  logic [15:0] count;
  modport source (output valid, action, frame_no, start_time, end_time, count,
                  input ready);
  modport sink (input valid, action, frame_no, start_time, end_time, count,
                output ready);
endinterface

interface frir_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] frame_no_out;
  logic [63:0] timestamp_out;
  logic [31:0] frame_interval_ns;
  logic [31:0] present_duration_ns;
  logic [12:0] stored_count;
  logic [31:0] average_interval_ns;
  logic [37:0] rate_q8;
  logic        last;
  modport source (output valid, status, frame_no_out, timestamp_out, frame_interval_ns,
                  present_duration_ns, stored_count, average_interval_ns, rate_q8, last,
                  input ready);
  modport sink (input valid, status, frame_no_out, timestamp_out, frame_interval_ns,
                present_duration_ns, stored_count, average_interval_ns, rate_q8, last,
                output ready);
endinterface

[rtl/frir_ram.sv]
// frir_ram: entry store, one write port and one registered read port
// depends on frir_pkg
module frir_ram
  import frir_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/frir_div.sv]
// frir_div: restoring divider, one quotient bit per cycle
// depends on frir_pkg
module frir_div
  import frir_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] num,
  input  logic [IV_W-1:0]  den,
  output logic             done,
  output logic [SUM_W-1:0] quo
);

  localparam int unsigned CW = $clog2(SUM_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W-1:0] num_r;
  logic [IV_W-1:0]  den_r;
  logic [IV_W:0]    rem_r;
  logic [IV_W:0]    rem_sh;
  logic             ge;
  logic [IV_W:0]    rem_new;

  // one shift and subtract step
  always_comb begin
    rem_sh  = {rem_r[IV_W-1:0], num_r[SUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_new = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[SUM_W-2:0], ge};
      rem_r <= rem_new;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

[rtl/frame_interval_ring_recorder_unit.sv]
// frame_interval_ring_recorder_unit: top level, sequencer around the entry store
// depends on frir_pkg, frir_if, frir_ram, frir_div
// sequence: record writes the store, latest reads the newest entry, frames since walks the stored entries,
// average and rate walk the window back from the newest entry, then run two 44-step divisions
// throughput: one item at a time; the next item is taken once the last result is registered
// reset: control, pointers, count and previous start cleared, rate_window set to 60;
// store contents are left undefined, only written entries are ever read
module frame_interval_ring_recorder_unit
  import frir_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  frir_in_if.sink     in_item,
  frir_out_if.source  out_item,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned VW = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;

  // captured item
  logic [2:0]  act_r;
  logic [63:0] fnum_r, start_r, end_r;
  logic [15:0] cnt_r;

  logic [AW-1:0]    wp_r, wp_nxt;
  logic [VW-1:0]    valid_r, valid_nxt;
  logic [63:0]      prev_r, prev_nxt;
  logic [CNT_W-1:0] rwin_r;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [VW-1:0]    idx_r, idx_nxt;
  logic [GOT_W-1:0] got_r, got_nxt;
  logic [GOT_W-1:0] limit_r, limit_nxt;
  logic             pend_v_r, pend_v_nxt;
  entry_t           pend_r, pend_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [VW-1:0]    k_r, k_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic             acc_v_r, acc_v_nxt;
  logic [IV_W-1:0]  avg_r, avg_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic             out_v_r, out_v_nxt;
  result_t          res_r, res_nxt;

  logic             slot_free;
  logic             emit;
  result_t          res_c;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_wdata, rdata;
  logic             div_start, div_done;
  logic [SUM_W-1:0] div_num, div_quo;
  logic [IV_W-1:0]  div_den;

  logic [AW-1:0]    newest, ptr_inc, ptr_dec;
  logic [VW:0]      old_t;
  logic [AW-1:0]    oldest;
  logic [63:0]      iv_diff, du_diff;
  entry_t           rec_e;
  logic [15:0]      win16;
  logic             match;
  logic [VW-1:0]    idx_inc;
  logic [GOT_W-1:0] got_inc;

  assign slot_free = !out_v_r || out_item.ready;
  assign in_item.ready = (state_r == S_IDLE);

  // ring address helpers
  always_comb begin
    newest  = (wp_r == '0) ? AW'(DEPTH - 1) : wp_r - 1'b1;
    ptr_inc = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    ptr_dec = (ptr_r == '0) ? AW'(DEPTH - 1) : ptr_r - 1'b1;
    old_t   = (VW + 1)'(wp_r) + (VW + 1)'(DEPTH) - (VW + 1)'(valid_r);
    oldest  = (old_t >= (VW + 1)'(DEPTH)) ? AW'(old_t - (VW + 1)'(DEPTH)) : AW'(old_t);
  end

  // new entry for a record item, window select and scan match
  always_comb begin
    iv_diff      = start_r - prev_r;
    du_diff      = end_r - start_r;
    rec_e.frame  = fnum_r;
    rec_e.stamp  = start_r;
    rec_e.interval = (prev_r == '0) ? '0 :
                     (iv_diff[63:32] != '0) ? 32'hFFFF_FFFF : iv_diff[31:0];
    rec_e.duration = (du_diff[63:32] != '0) ? 32'hFFFF_FFFF : du_diff[31:0];
    win16 = (act_r == ACT_AVG) ? cnt_r : 16'(rwin_r);
    match   = rdata.frame > fnum_r;
    idx_inc = idx_r + 1'b1;
    got_inc = got_r + 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_item.valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (act_r)
          ACT_LATEST: begin
            if (valid_r == '0) begin
              if (slot_free) state_nxt = S_IDLE;
            end else begin
              state_nxt = S_LAT;
            end
          end
          ACT_SINCE: begin
            if (valid_r == '0 || cnt_r == '0) state_nxt = S_SCAN_END;
            else state_nxt = S_SCAN_RD;
          end
          ACT_AVG, ACT_RATE: state_nxt = S_AVG;
          default: begin
            if (slot_free) state_nxt = S_IDLE;
          end
        endcase
      end
      S_LAT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (!(match && pend_v_r && !slot_free)) begin
          if (idx_inc == valid_r || (match && got_inc == limit_r)) state_nxt = S_SCAN_END;
          else state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_AVG: begin
        if (rem_r == '0 && !acc_v_r) begin
          state_nxt = (k_r == '0) ? S_AVG_OUT : S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) state_nxt = S_DIV2;
      end
      S_DIV2: begin
        if (div_done) state_nxt = S_AVG_OUT;
      end
      S_AVG_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt     = wp_r;
    valid_nxt  = valid_r;
    prev_nxt   = prev_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    got_nxt    = got_r;
    limit_nxt  = limit_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    sum_nxt    = sum_r;
    k_nxt      = k_r;
    rem_nxt    = rem_r;
    acc_v_nxt  = 1'b0;
    avg_nxt    = avg_r;
    rate_nxt   = rate_r;
    mem_we     = 1'b0;
    mem_wdata  = rec_e;
    mem_re     = 1'b0;
    mem_raddr  = ptr_r;
    div_start  = 1'b0;
    div_num    = sum_r;
    div_den    = IV_W'(k_r);
    emit       = 1'b0;
    res_c      = '0;
    res_c.last = 1'b1;

    case (state_r)
      S_DISPATCH: begin
        case (act_r)
          ACT_RECORD: begin
            if (slot_free) begin
              emit      = 1'b1;
              mem_we    = 1'b1;
              prev_nxt  = start_r;
              wp_nxt    = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
              valid_nxt = (valid_r == VW'(DEPTH)) ? valid_r : valid_r + 1'b1;
              res_c.frame_no_out        = rec_e.frame;
              res_c.timestamp_out       = rec_e.stamp;
              res_c.frame_interval_ns   = rec_e.interval;
              res_c.present_duration_ns = rec_e.duration;
            end
          end
          ACT_LATEST: begin
            if (valid_r == '0) begin
              emit = slot_free;
              res_c.status = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = newest;
            end
          end
          ACT_SINCE: begin
            ptr_nxt    = oldest;
            idx_nxt    = '0;
            got_nxt    = '0;
            pend_v_nxt = 1'b0;
            limit_nxt  = (cnt_r < 16'(MAX_RES)) ? GOT_W'(cnt_r) : MAX_RES;
          end
          ACT_AVG, ACT_RATE: begin
            ptr_nxt = newest;
            rem_nxt = (win16 < 16'(valid_r)) ? VW'(win16) : valid_r;
            sum_nxt = '0;
            k_nxt   = '0;
            avg_nxt = '0;
            rate_nxt = '0;
          end
          ACT_CLEAR: begin
            emit = slot_free;
            if (slot_free) begin
              wp_nxt    = '0;
              valid_nxt = '0;
              prev_nxt  = '0;
            end
          end
          default: begin
            emit = slot_free;
            res_c.status = 1'b1;
          end
        endcase
      end
      S_LAT: begin
        emit = slot_free;
        res_c.frame_no_out        = rdata.frame;
        res_c.timestamp_out       = rdata.stamp;
        res_c.frame_interval_ns   = rdata.interval;
        res_c.present_duration_ns = rdata.duration;
      end
      S_SCAN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ptr_r;
      end
      S_SCAN_CHK: begin
        if (!(match && pend_v_r && !slot_free)) begin
          idx_nxt = idx_inc;
          ptr_nxt = ptr_inc;
          if (match) begin
            got_nxt    = got_inc;
            pend_v_nxt = 1'b1;
            pend_nxt   = rdata;
            // an earlier match goes out now, it is not the final one
            if (pend_v_r) begin
              emit       = 1'b1;
              res_c.last = 1'b0;
              res_c.frame_no_out        = pend_r.frame;
              res_c.timestamp_out       = pend_r.stamp;
              res_c.frame_interval_ns   = pend_r.interval;
              res_c.present_duration_ns = pend_r.duration;
            end
          end
        end
      end
      S_SCAN_END: begin
        emit = slot_free;
        if (pend_v_r) begin
          res_c.frame_no_out        = pend_r.frame;
          res_c.timestamp_out       = pend_r.stamp;
          res_c.frame_interval_ns   = pend_r.interval;
          res_c.present_duration_ns = pend_r.duration;
        end else begin
          res_c.status = 1'b1;
        end
      end
      S_AVG: begin
        // streamed walk from newest back, read and accumulate overlap
        if (rem_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          ptr_nxt   = ptr_dec;
          rem_nxt   = rem_r - 1'b1;
          acc_v_nxt = 1'b1;
        end
        if (acc_v_r && rdata.interval != '0) begin
          sum_nxt = sum_r + SUM_W'(rdata.interval);
          k_nxt   = k_r + 1'b1;
        end
        if (rem_r == '0 && !acc_v_r && k_r != '0) begin
          div_start = 1'b1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          avg_nxt   = div_quo[IV_W-1:0];
          div_start = 1'b1;
          div_num   = RATE_NUM;
          div_den   = div_quo[IV_W-1:0];
        end
      end
      S_DIV2: begin
        if (div_done) rate_nxt = div_quo[RATE_W-1:0];
      end
      S_AVG_OUT: begin
        emit = slot_free;
        res_c.status              = (k_r == '0);
        res_c.average_interval_ns = avg_r;
        res_c.rate_q8             = rate_r;
      end
      default: ;
    endcase

    res_c.stored_count = CNT_W'(valid_nxt);
    out_v_nxt = emit ? 1'b1 : (out_item.ready ? 1'b0 : out_v_r);
    res_nxt   = emit ? res_c : res_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      valid_r  <= '0;
      prev_r   <= '0;
      rwin_r   <= RATE_WIN_RST;
      out_v_r  <= 1'b0;
      acc_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      valid_r  <= valid_nxt;
      prev_r   <= prev_nxt;
      out_v_r  <= out_v_nxt;
      acc_v_r  <= acc_v_nxt;
      pend_v_r <= pend_v_nxt;
      if (cfg_we) rwin_r <= cfg_wdata;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      act_r   <= in_item.action;
      fnum_r  <= in_item.frame_no;
      start_r <= in_item.start_time;
      end_r   <= in_item.end_time;
      cnt_r   <= in_item.count;
    end
    ptr_r   <= ptr_nxt;
    idx_r   <= idx_nxt;
    got_r   <= got_nxt;
    limit_r <= limit_nxt;
    pend_r  <= pend_nxt;
    sum_r   <= sum_nxt;
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    avg_r   <= avg_nxt;
    rate_r  <= rate_nxt;
    res_r   <= res_nxt;
  end

  frir_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  frir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // result channel
  assign out_item.valid               = out_v_r;
  assign out_item.status              = res_r.status;
  assign out_item.frame_no_out        = res_r.frame_no_out;
  assign out_item.timestamp_out       = res_r.timestamp_out;
  assign out_item.frame_interval_ns   = res_r.frame_interval_ns;
  assign out_item.present_duration_ns = res_r.present_duration_ns;
  assign out_item.stored_count        = res_r.stored_count;
  assign out_item.average_interval_ns = res_r.average_interval_ns;
  assign out_item.rate_q8             = res_r.rate_q8;
  assign out_item.last                = res_r.last;

endmodule

[tb/tb_frame_interval_ring_recorder_unit.sv]
// tb_frame_interval_ring_recorder_unit: self-checking bench for the frame interval recorder
// drives request items, predicts every result item in-bench and checks them in order
// depends on frir_pkg, frir_if and the recorder rtl
`timescale 1ns / 1ps
module tb_frame_interval_ring_recorder_unit;
  import frir_pkg::*;

  localparam int unsigned RING = 64;
  localparam logic [63:0] RATE_DIVIDEND = 64'd256000000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [12:0] cfg_wdata;

  frir_in_if in_item ();
  frir_out_if out_item ();

  frame_interval_ring_recorder_unit #(.DEPTH(RING)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item.sink),
    .out_item (out_item.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predicted recorder state
  entry_t      ring_entries [RING];
  int unsigned ring_wr;
  int unsigned ring_fill;
  logic [63:0] last_start;
  logic [12:0] window_reg;

  result_t     pending_results[$];
  int          err_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic [63:0] next_frame;
  logic [63:0] next_start;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] sat_ns(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic result_t blank_result(logic st);
    result_t r;
    r = '0;
    r.status = st;
    r.stored_count = ring_fill[12:0];
    return r;
  endfunction

  function automatic result_t entry_result(entry_t e);
    result_t r;
    r = blank_result(1'b0);
    r.frame_no_out = e.frame;
    r.timestamp_out = e.stamp;
    r.frame_interval_ns = e.interval;
    r.present_duration_ns = e.duration;
    return r;
  endfunction

  // mean of nonzero intervals over the newest frames, with q8 rate
  function automatic result_t mean_interval(int unsigned span);
    int unsigned n, k, idx;
    logic [63:0] sum, avg;
    result_t r;
    n = (span < ring_fill) ? span : ring_fill;
    sum = 0;
    k = 0;
    for (int unsigned i = 0; i < n; i++) begin
      idx = (ring_wr + RING - 1 - i) % RING;
      if (ring_entries[idx].interval != 0) begin
        sum += 64'(ring_entries[idx].interval);
        k++;
      end
    end
    r = blank_result(k == 0);
    if (k != 0) begin
      avg = sum / 64'(k);
      r.average_interval_ns = avg[31:0];
      if (avg != 0) r.rate_q8 = RATE_W'(RATE_DIVIDEND / avg);
    end
    return r;
  endfunction

  // update recorder state and queue the result items of one request
  task automatic predict_request(logic [2:0] act, logic [63:0] fnum, logic [63:0] st,
                                 logic [63:0] en, logic [15:0] cnt);
    result_t outs[$];
    entry_t e;
    int unsigned lim, oldest;
    case (act)
      ACT_RECORD: begin
        e.frame = fnum;
        e.stamp = st;
        e.interval = (last_start != 0) ? sat_ns(st - last_start) : 32'd0;
        e.duration = sat_ns(en - st);
        ring_entries[ring_wr] = e;
        last_start = st;
        ring_wr = (ring_wr + 1) % RING;
        if (ring_fill < RING) ring_fill++;
        outs.push_back(entry_result(e));
      end
      ACT_LATEST: begin
        if (ring_fill == 0) outs.push_back(blank_result(1'b1));
        else outs.push_back(entry_result(ring_entries[(ring_wr + RING - 1) % RING]));
      end
      ACT_SINCE: begin
        lim = (cnt < 16'(MAX_RES)) ? 32'(cnt) : 32'(MAX_RES);
        oldest = (ring_wr + RING - ring_fill) % RING;
        for (int unsigned i = 0; i < ring_fill && outs.size() < lim; i++) begin
          e = ring_entries[(oldest + i) % RING];
          if (e.frame > fnum) outs.push_back(entry_result(e));
        end
        if (outs.size() == 0) outs.push_back(blank_result(1'b1));
      end
      ACT_AVG: outs.push_back(mean_interval(32'(cnt)));
      ACT_CLEAR: begin
        ring_wr = 0;
        ring_fill = 0;
        last_start = 0;
        outs.push_back(blank_result(1'b0));
      end
      ACT_RATE: outs.push_back(mean_interval(32'(window_reg)));
      default: outs.push_back(blank_result(1'b1));
    endcase
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) pending_results.push_back(outs[i]);
  endtask

  // result receiver: random stalls, in-order field check
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      out_item.ready <= 1'b0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result item frame=%h", $time, out_item.frame_no_out);
          err_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_item.status !== exp_r.status ||
              out_item.frame_no_out !== exp_r.frame_no_out ||
              out_item.timestamp_out !== exp_r.timestamp_out ||
              out_item.frame_interval_ns !== exp_r.frame_interval_ns ||
              out_item.present_duration_ns !== exp_r.present_duration_ns ||
              out_item.stored_count !== exp_r.stored_count ||
              out_item.average_interval_ns !== exp_r.average_interval_ns ||
              out_item.rate_q8 !== exp_r.rate_q8 ||
              out_item.last !== exp_r.last) begin
            $display("%0t mismatch exp st=%b fr=%h ts=%h iv=%h du=%h n=%0d avg=%h q8=%h l=%b",
                     $time, exp_r.status, exp_r.frame_no_out, exp_r.timestamp_out,
                     exp_r.frame_interval_ns, exp_r.present_duration_ns, exp_r.stored_count,
                     exp_r.average_interval_ns, exp_r.rate_q8, exp_r.last);
            $display("%0t          got st=%b fr=%h ts=%h iv=%h du=%h n=%0d avg=%h q8=%h l=%b",
                     $time, out_item.status, out_item.frame_no_out, out_item.timestamp_out,
                     out_item.frame_interval_ns, out_item.present_duration_ns,
                     out_item.stored_count, out_item.average_interval_ns, out_item.rate_q8,
                     out_item.last);
            err_count++;
          end
        end
      end
      out_item.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one request item; valid stays high unless a gap is taken
  task automatic send_request(logic [2:0] act, logic [63:0] fnum, logic [63:0] st,
                              logic [63:0] en, logic [15:0] cnt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_item.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_item.valid <= 1'b1;
    in_item.action <= act;
    in_item.frame_no <= fnum;
    in_item.start_time <= st;
    in_item.end_time <= en;
    in_item.count <= cnt;
    do @(posedge clk); while (!in_item.ready);
    predict_request(act, fnum, st, en, cnt);
  endtask

  // drop valid and wait until every expected result item has arrived
  task automatic drain_results();
    in_item.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(logic [12:0] w);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = w;
  endtask

  task automatic record_frame(logic [63:0] st, logic [63:0] en);
    send_request(ACT_RECORD, next_frame, st, en, 16'($urandom));
    next_frame += 1;
  endtask

  // empty store, first frame, saturation and wrap, unknown actions
  task automatic test_directed();
    send_request(ACT_LATEST, '1, '1, '1, '1);
    send_request(ACT_SINCE, 64'd0, 64'd0, 64'd0, 16'hFFFF);
    send_request(ACT_AVG, 64'd0, 64'd0, 64'd0, 16'd10);
    send_request(ACT_RATE, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_RECORD, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_RECORD, '1, 64'd1000, '1, 16'hFFFF);
    send_request(ACT_RECORD, 64'd5, 64'd17_000_000, 64'd17_004_000, 16'd0);
    send_request(ACT_RECORD, 64'd6, '1, 64'd3, 16'd0);
    send_request(ACT_RECORD, 64'd7, 64'd0, 64'hFFFF_FFFF, 16'd0);
    send_request(ACT_RECORD, 64'd8, 64'd16_666_667, 64'd16_666_667, 16'd0);
    send_request(ACT_LATEST, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_SINCE, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_SINCE, 64'd5, 64'd0, 64'd0, 16'd2);
    send_request(ACT_SINCE, '1, 64'd0, 64'd0, 16'd64);
    send_request(ACT_AVG, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_AVG, 64'd0, 64'd0, 64'd0, 16'hFFFF);
    send_request(ACT_RATE, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(3'd6, '1, '1, '1, '1);
    send_request(3'd7, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_CLEAR, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_LATEST, 64'd0, 64'd0, 64'd0, 16'd0);
    send_request(ACT_RATE, 64'd0, 64'd0, 64'd0, 16'd0);
  endtask

  // mostly steady frame streams, with queries, clears and raw noise mixed in
  task automatic test_random(int unsigned n_items);
    int unsigned pick;
    logic [63:0] st, en, fnum;
    logic [15:0] cnt;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      cnt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(80));
      if (pick < 52) begin
        case ($urandom_range(9))
          0: st = {$urandom, $urandom};
          1: st = 64'd0;
          default: st = next_start + 64'($urandom_range(2_000_000, 40_000_000));
        endcase
        if ($urandom_range(7) == 0) st = next_start + 64'd5_000_000_000;
        en = ($urandom_range(5) == 0) ? {$urandom, $urandom}
                                      : st + 64'($urandom_range(900_000));
        next_start = st;
        if ($urandom_range(11) == 0) next_frame = {$urandom, $urandom};
        record_frame(st, en);
      end else if (pick < 62) begin
        send_request(ACT_LATEST, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
      end else if (pick < 77) begin
        fnum = ($urandom_range(4) == 0) ? {$urandom, $urandom}
                                        : next_frame - 64'($urandom_range(70));
        send_request(ACT_SINCE, fnum, {$urandom, $urandom}, {$urandom, $urandom}, cnt);
      end else if (pick < 87) begin
        send_request(ACT_AVG, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, cnt);
      end else if (pick < 94) begin
        send_request(ACT_RATE, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
      end else if (pick < 96) begin
        send_request(ACT_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
      end else begin
        send_request(3'($urandom_range(6, 7)), {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
      end
    end
  endtask

  // window register at 1, 4096, 2 and a random value in between
  task automatic test_rate_window();
    logic [12:0] settings [4];
    settings = '{13'd1, 13'd4096, 13'd2, 13'($urandom_range(3, 4095))};
    foreach (settings[s]) begin
      write_window(settings[s]);
      for (int unsigned i = 0; i < 3; i++) begin
        next_start += 64'($urandom_range(1_000_000, 30_000_000));
        record_frame(next_start, next_start + 64'd1000);
      end
      send_request(ACT_RATE, 64'd0, 64'd0, 64'd0, 16'd0);
    end
    write_window(RATE_WIN_RST);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_item.valid <= 1'b0;
    in_item.action <= ACT_LATEST;
    in_item.frame_no <= '0;
    in_item.start_time <= '0;
    in_item.end_time <= '0;
    in_item.count <= '0;
    err_count = 0;
    ring_wr = 0;
    ring_fill = 0;
    last_start = 0;
    window_reg = RATE_WIN_RST;
    next_frame = 64'd100;
    next_start = 64'd1_000_000;
    send_idle_pct = 13;
    recv_idle_pct = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_rate_window();
    test_random(130);
    drain_results();
    send_idle_pct = 64;
    recv_idle_pct = 13;
    test_random(130);
    write_window(13'd4096);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);

    drain_results();
    repeat (200) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
